// File: hw/rtl/fcst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: shared definitions
// Widths, reset values, state codes and types shared by the transition unit.
// ----------------------------------------------------------------------------
package fcst_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int FIELD_W       = 17;
	localparam int DRAW_W        = 16;
	localparam int STATE_W       = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int SUM_W         = FIELD_W + 1;
	localparam int PROD_W        = FIELD_W + SUM_W;
	localparam int TERM_W        = PROD_W - FRACTION_BITS;
	localparam int ACC_W         = TERM_W + 3;

	localparam longint ONE_VAL = longint'(1) << FRACTION_BITS;

	localparam logic [FIELD_W-1:0] RST_HALF    = FIELD_W'(ONE_VAL / 2);
	localparam logic [FIELD_W-1:0] RST_QUARTER = FIELD_W'(ONE_VAL / 4);
	localparam logic [FIELD_W-1:0] RST_FIFTH   = FIELD_W'((ONE_VAL * 2 + 5) / 10);
	localparam logic [FIELD_W-1:0] RST_TENTH   = FIELD_W'((ONE_VAL + 5) / 10);

	localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(ONE_VAL);

	typedef enum logic [STATE_W-1:0] {
		ST_MIXED  = 2'd0,
		ST_DECID  = 2'd1,
		ST_CONIF  = 2'd2,
		ST_TRANS  = 2'd3
	} forest_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONIF_COEF   = 3'd0,
		REG_DECID_COEF   = 3'd1,
		REG_MIX_TO_CONIF = 3'd2,
		REG_MIX_TO_DECID = 3'd3,
		REG_TR_TO_DECID  = 3'd4,
		REG_TR_TO_CONIF  = 3'd5,
		REG_TR_TO_MIX    = 3'd6,
		REG_DISTURB      = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [FIELD_W-1:0] coef_spread_to_mixed_from_conifer;
		logic [FIELD_W-1:0] coef_spread_to_mixed_from_decid;
		logic [FIELD_W-1:0] mixed_to_conifer_prob;
		logic [FIELD_W-1:0] mixed_to_decid_prob;
		logic [FIELD_W-1:0] trans_to_decid_prob;
		logic [FIELD_W-1:0] trans_to_conifer_prob;
		logic [FIELD_W-1:0] trans_to_mixed_prob;
		logic [FIELD_W-1:0] disturbance_prob;
	} cfg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] p_mixed;
		logic signed [ACC_W-1:0] p_decid;
		logic signed [ACC_W-1:0] p_conif;
		logic signed [ACC_W-1:0] p_trans;
	} prob_t;

	function automatic logic signed [ACC_W-1:0] field_to_acc(input logic [FIELD_W-1:0] v);
		return signed'({{(ACC_W-FIELD_W){1'b0}}, v});
	endfunction

	function automatic logic signed [ACC_W-1:0] term_to_acc(input logic [TERM_W-1:0] v);
		return signed'({{(ACC_W-TERM_W){1'b0}}, v});
	endfunction

endpackage

// File: hw/rtl/fcst_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: cell item channel
// Valid/ready channel carrying one cell's state, prevalences and draw.
// ----------------------------------------------------------------------------
interface fcst_item_if;
	import fcst_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATE_W-1:0]    current_state;
	logic [FIELD_W-1:0]    prev_conifer;
	logic [FIELD_W-1:0]    prev_mixed;
	logic [FIELD_W-1:0]    prev_decid;
	logic [DRAW_W-1:0]     random_draw;

	modport source (
		output valid, current_state, prev_conifer, prev_mixed, prev_decid, random_draw,
		input  ready
	);
	modport sink (
		input  valid, current_state, prev_conifer, prev_mixed, prev_decid, random_draw,
		output ready
	);
endinterface

// File: hw/rtl/fcst_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: result channel
// Valid/ready channel carrying the chosen next state of one cell.
// ----------------------------------------------------------------------------
interface fcst_result_if;
	import fcst_pkg::*;

	logic               valid;
	logic               ready;
	logic [STATE_W-1:0] next_state;

	modport source (output valid, next_state, input ready);
	modport sink (input valid, next_state, output ready);
endinterface

// File: hw/rtl/fcst_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fcst_cfg_if;
	import fcst_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FIELD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/forest_cell_stochastic_transition_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition unit
// Chooses the next state of one forest cell per word from its neighborhood
// prevalences, the coefficient registers and a uniform draw.
//
//   channel       role   word
//   cell_item     sink   current_state, prevalences, random_draw
//   cell_result   source next_state
//   cfg           sink   register index, 17-bit data
//
// A word passes the input register, the probability register after the
// colonization multiply and the result register. One word is accepted per
// cycle unless all stages are full under a stalled result; each stage moves
// on when the stage after it is empty or moving, so bubbles close up.
// Reset clears the stage valid bits and loads the register reset values.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module forest_cell_stochastic_transition_unit (
	input  logic          clk,
	input  logic          arst_n,
	fcst_item_if.sink     cell_item,
	fcst_result_if.source cell_result,
	fcst_cfg_if.sink      cfg
);
	import fcst_pkg::*;

	cfg_t               cfg_regs;
	logic               v_s1;
	logic               v_s2;
	logic               out_valid_q;
	logic               rdy_s1;
	logic               rdy_s2;
	logic               rdy_out;
	logic [STATE_W-1:0] state_s1;
	logic [FIELD_W-1:0] prev_conifer_s1;
	logic [FIELD_W-1:0] prev_mixed_s1;
	logic [FIELD_W-1:0] prev_decid_s1;
	logic [DRAW_W-1:0]  draw_s1;
	logic [DRAW_W-1:0]  draw_s2;
	prob_t              prob_comb;
	prob_t              prob_s2;
	logic [STATE_W-1:0] next_state_comb;
	logic [STATE_W-1:0] next_state_q;

	assign cfg.ready = 1'b1;

	fcst_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	assign rdy_out         = !out_valid_q || cell_result.ready;
	assign rdy_s2          = !v_s2 || rdy_out;
	assign rdy_s1          = !v_s1 || rdy_s2;
	assign cell_item.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= cell_item.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && cell_item.valid) begin
			state_s1        <= cell_item.current_state;
			prev_conifer_s1 <= cell_item.prev_conifer;
			prev_mixed_s1   <= cell_item.prev_mixed;
			prev_decid_s1   <= cell_item.prev_decid;
			draw_s1         <= cell_item.random_draw;
		end
		if (rdy_s2 && v_s1) begin
			prob_s2 <= prob_comb;
			draw_s2 <= draw_s1;
		end
		if (rdy_out && v_s2) begin
			next_state_q <= next_state_comb;
		end
	end

	fcst_prob u_prob (
		.current_state (state_s1),
		.prev_conifer  (prev_conifer_s1),
		.prev_mixed    (prev_mixed_s1),
		.prev_decid    (prev_decid_s1),
		.cfg           (cfg_regs),
		.prob          (prob_comb)
	);

	fcst_select u_select (
		.prob        (prob_s2),
		.random_draw (draw_s2),
		.next_state  (next_state_comb)
	);

	assign cell_result.valid      = out_valid_q;
	assign cell_result.next_state = next_state_q;

	a_item_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_item.valid && cell_item.ready) |=> v_s1)
		else $error("accepted word did not reach the input register");

	a_s2_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy_out) |=> out_valid_q)
		else $error("probability stage word did not reach the result register");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !cell_result.ready && v_s2 && v_s1) |-> !cell_item.ready)
		else $error("word accepted while every stage is full and stalled");

	a_hold_stalled_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy_out) |=> (v_s2 && $stable(draw_s2)))
		else $error("probability stage lost its word under a stall");

endmodule

// File: hw/rtl/fcst_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: configuration registers
// Eight 17-bit coefficient and probability registers written by index.
// ----------------------------------------------------------------------------
module fcst_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fcst_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [fcst_pkg::FIELD_W-1:0]  wr_data,
	output fcst_pkg::cfg_t                cfg
);
	import fcst_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_spread_to_mixed_from_conifer <= RST_HALF;
			cfg_q.coef_spread_to_mixed_from_decid   <= RST_HALF;
			cfg_q.mixed_to_conifer_prob             <= RST_QUARTER;
			cfg_q.mixed_to_decid_prob               <= RST_QUARTER;
			cfg_q.trans_to_decid_prob               <= RST_FIFTH;
			cfg_q.trans_to_conifer_prob             <= RST_FIFTH;
			cfg_q.trans_to_mixed_prob               <= RST_FIFTH;
			cfg_q.disturbance_prob                  <= RST_TENTH;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				REG_CONIF_COEF:   cfg_q.coef_spread_to_mixed_from_conifer <= wr_data;
				REG_DECID_COEF:   cfg_q.coef_spread_to_mixed_from_decid   <= wr_data;
				REG_MIX_TO_CONIF: cfg_q.mixed_to_conifer_prob             <= wr_data;
				REG_MIX_TO_DECID: cfg_q.mixed_to_decid_prob               <= wr_data;
				REG_TR_TO_DECID:  cfg_q.trans_to_decid_prob               <= wr_data;
				REG_TR_TO_CONIF:  cfg_q.trans_to_conifer_prob             <= wr_data;
				REG_TR_TO_MIX:    cfg_q.trans_to_mixed_prob               <= wr_data;
				REG_DISTURB:      cfg_q.disturbance_prob                  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/fcst_prob.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: probability former
// Forms the four transition probabilities of one cell, including the
// colonization product and the self-transition remainder.
// ----------------------------------------------------------------------------
module fcst_prob (
	input  logic [fcst_pkg::STATE_W-1:0] current_state,
	input  logic [fcst_pkg::FIELD_W-1:0] prev_conifer,
	input  logic [fcst_pkg::FIELD_W-1:0] prev_mixed,
	input  logic [fcst_pkg::FIELD_W-1:0] prev_decid,
	input  fcst_pkg::cfg_t               cfg,
	output fcst_pkg::prob_t              prob
);
	import fcst_pkg::*;

	logic [FIELD_W-1:0]      spread_coef;
	logic [SUM_W-1:0]        spread_sum;
	logic [PROD_W-1:0]       spread_prod;
	logic signed [ACC_W-1:0] spread_term;
	logic signed [ACC_W-1:0] disturb;

	always_comb begin
		if (forest_state_t'(current_state) == ST_DECID) begin
			spread_coef = cfg.coef_spread_to_mixed_from_decid;
			spread_sum  = SUM_W'(prev_conifer) + SUM_W'(prev_mixed);
		end else begin
			spread_coef = cfg.coef_spread_to_mixed_from_conifer;
			spread_sum  = SUM_W'(prev_mixed) + SUM_W'(prev_decid);
		end
		spread_prod = PROD_W'(spread_coef) * PROD_W'(spread_sum);
		spread_term = term_to_acc(spread_prod[PROD_W-1:FRACTION_BITS]);
		disturb     = field_to_acc(cfg.disturbance_prob);
	end

	always_comb begin
		case (forest_state_t'(current_state))
			ST_MIXED: begin
				prob.p_decid = field_to_acc(cfg.mixed_to_decid_prob);
				prob.p_conif = field_to_acc(cfg.mixed_to_conifer_prob);
				prob.p_trans = disturb;
				prob.p_mixed = ONE_ACC - (prob.p_decid + prob.p_conif + prob.p_trans);
			end
			ST_DECID: begin
				prob.p_mixed = spread_term;
				prob.p_conif = '0;
				prob.p_trans = disturb;
				prob.p_decid = ONE_ACC - (prob.p_mixed + prob.p_trans);
			end
			ST_CONIF: begin
				prob.p_mixed = spread_term;
				prob.p_decid = '0;
				prob.p_trans = disturb;
				prob.p_conif = ONE_ACC - (prob.p_mixed + prob.p_trans);
			end
			default: begin
				prob.p_mixed = field_to_acc(cfg.trans_to_mixed_prob);
				prob.p_decid = field_to_acc(cfg.trans_to_decid_prob);
				prob.p_conif = field_to_acc(cfg.trans_to_conifer_prob);
				prob.p_trans = ONE_ACC - (prob.p_mixed + prob.p_decid + prob.p_conif);
			end
		endcase
	end

endmodule

// File: hw/rtl/fcst_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forest cell stochastic transition: state selector
// Walks the signed cumulative sum; first state above the draw, else mixed.
// ----------------------------------------------------------------------------
module fcst_select (
	input  fcst_pkg::prob_t              prob,
	input  logic [fcst_pkg::DRAW_W-1:0]  random_draw,
	output logic [fcst_pkg::STATE_W-1:0] next_state
);
	import fcst_pkg::*;

	logic signed [ACC_W-1:0] draw_acc;
	logic signed [ACC_W-1:0] cum_mixed;
	logic signed [ACC_W-1:0] cum_decid;
	logic signed [ACC_W-1:0] cum_conif;
	logic signed [ACC_W-1:0] cum_trans;

	always_comb begin
		draw_acc  = signed'({{(ACC_W-DRAW_W){1'b0}}, random_draw});
		cum_mixed = prob.p_mixed;
		cum_decid = cum_mixed + prob.p_decid;
		cum_conif = cum_decid + prob.p_conif;
		cum_trans = cum_conif + prob.p_trans;
		if (draw_acc < cum_mixed) begin
			next_state = ST_MIXED;
		end else if (draw_acc < cum_decid) begin
			next_state = ST_DECID;
		end else if (draw_acc < cum_conif) begin
			next_state = ST_CONIF;
		end else if (draw_acc < cum_trans) begin
			next_state = ST_TRANS;
		end else begin
			next_state = ST_MIXED;
		end
	end

endmodule
